### sv/ddq_pkg.sv
// ----------------------------------------------------------------------------
// ddq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package ddq_pkg;

	localparam int unsigned DEPTH_DEFAULT = 1024;
	localparam int unsigned CAP_W         = 11;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned OP_W          = 3;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 11'd1024;
	localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_LOAD
	} ddq_state_t;

endpackage

### sv/ddq_store.sv
// ----------------------------------------------------------------------------
// ddq_store
// Entry memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ddq_store #(
	parameter int unsigned DEPTH = ddq_pkg::DEPTH_DEFAULT,
	parameter int unsigned PW    = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [PW-1:0]               waddr,
	input  logic [ddq_pkg::WORD_W-1:0]  wdata,
	input  logic                        re,
	input  logic [PW-1:0]               raddr0,
	input  logic [PW-1:0]               raddr1,
	output logic [ddq_pkg::WORD_W-1:0]  rdata0,
	output logic [ddq_pkg::WORD_W-1:0]  rdata1
);

	logic [ddq_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

### sv/ddq_ctrl.sv
// ----------------------------------------------------------------------------
// ddq_ctrl
// Request sequencer: pointer/count update, memory access, result register.
// ----------------------------------------------------------------------------
module ddq_ctrl #(
	parameter int unsigned DEPTH = ddq_pkg::DEPTH_DEFAULT,
	parameter int unsigned PW    = 10,
	parameter int unsigned CW    = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ddq_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ddq_pkg::OP_W-1:0]    in_op,
	input  logic [ddq_pkg::WORD_W-1:0]  in_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        out_ok,
	output logic [ddq_pkg::WORD_W-1:0]  out_front,
	output logic [ddq_pkg::WORD_W-1:0]  out_rear,
	output logic                        out_empty,
	output logic                        out_full,
	output logic                        mem_we,
	output logic [PW-1:0]               mem_waddr,
	output logic [ddq_pkg::WORD_W-1:0]  mem_wdata,
	output logic                        mem_re,
	output logic [PW-1:0]               mem_raddr0,
	output logic [PW-1:0]               mem_raddr1,
	input  logic [ddq_pkg::WORD_W-1:0]  mem_rdata0,
	input  logic [ddq_pkg::WORD_W-1:0]  mem_rdata1
);

	localparam int unsigned MW = (CW > ddq_pkg::CAP_W) ? CW : ddq_pkg::CAP_W;

	ddq_pkg::ddq_state_t state_q, state_d;

	logic [PW-1:0]                head_q, head_d;
	logic [CW-1:0]                count_q, count_d;
	logic [ddq_pkg::CAP_W-1:0]    cap_q;
	logic [ddq_pkg::OP_W-1:0]     op_q;
	logic [ddq_pkg::WORD_W-1:0]   value_q;
	logic                         ok_q, ok_d;
	logic                         out_valid_q;
	logic                         load;
	logic                         wr_req;
	logic [PW-1:0]                wr_addr;
	logic [MW-1:0]                cap_eff;
	logic                         full_now;
	logic                         empty_now;

	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] t;
		t = (CW+1)'(a) + (CW+1)'(b);
		if (t >= (CW+1)'(DEPTH)) begin
			t = t - (CW+1)'(DEPTH);
		end
		return t[PW-1:0];
	endfunction

	assign cap_eff   = (MW'(cap_q) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(cap_q);
	assign full_now  = MW'(count_q) >= cap_eff;
	assign empty_now = (count_q == '0);

	// operation decode, evaluated in the execute cycle
	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		ok_d    = 1'b1;
		wr_req  = 1'b0;
		wr_addr = head_q;
		case (op_q)
			ddq_pkg::OP_PUSH_FRONT: begin
				if (full_now) begin
					ok_d = 1'b0;
				end else begin
					head_d  = (head_q == '0) ? PW'(DEPTH - 1) : head_q - 1'b1;
					wr_addr = head_d;
					wr_req  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			ddq_pkg::OP_PUSH_BACK: begin
				if (full_now) begin
					ok_d = 1'b0;
				end else begin
					wr_addr = ring_add(head_q, count_q);
					wr_req  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			ddq_pkg::OP_POP_FRONT: begin
				if (empty_now) begin
					ok_d = 1'b0;
				end else begin
					head_d  = ring_add(head_q, CW'(1));
					count_d = count_q - 1'b1;
				end
			end
			ddq_pkg::OP_POP_BACK: begin
				if (empty_now) begin
					ok_d = 1'b0;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ddq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ddq_pkg::ST_EXEC;
				end
			end
			ddq_pkg::ST_EXEC: state_d = ddq_pkg::ST_READ;
			ddq_pkg::ST_READ: state_d = ddq_pkg::ST_LOAD;
			ddq_pkg::ST_LOAD: begin
				if (!out_valid_q || out_ready) begin
					state_d = ddq_pkg::ST_IDLE;
				end
			end
			default: state_d = ddq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		load       = 1'b0;
		case (state_q)
			ddq_pkg::ST_IDLE: in_ready = 1'b1;
			ddq_pkg::ST_EXEC: mem_we   = wr_req;
			ddq_pkg::ST_READ: mem_re   = 1'b1;
			ddq_pkg::ST_LOAD: load     = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	assign mem_waddr  = wr_addr;
	assign mem_wdata  = value_q;
	assign mem_raddr0 = head_q;
	assign mem_raddr1 = ring_add(head_q, count_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ddq_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			cap_q       <= ddq_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ddq_pkg::ST_EXEC) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
			if (cfg_we && count_q == '0) begin
				cap_q <= cfg_wdata;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= in_op;
			value_q <= in_value;
		end
		if (state_q == ddq_pkg::ST_EXEC) begin
			ok_q <= ok_d;
		end
		if (load) begin
			out_ok    <= ok_q;
			out_front <= empty_now ? ddq_pkg::EMPTY_WORD : mem_rdata0;
			out_rear  <= empty_now ? ddq_pkg::EMPTY_WORD : mem_rdata1;
			out_empty <= empty_now;
			out_full  <= full_now;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Ring-buffer deque of 32-bit words with a run-time capacity limit.
// ----------------------------------------------------------------------------
// One request is handled at a time: it is taken, the head pointer and count
// are updated with the push written to the entry memory, then front and rear
// are read from the memory's two read ports and loaded into the result
// register. The next request is accepted only after that load, an order set
// by the write-then-read sequence on the synchronous memory with registered
// reads; the load waits while the output register still holds an untaken
// result, and a new request is accepted while a loaded result waits to be taken.
// Capacity is written through cfg_we/cfg_wdata and is ignored unless the
// queue is empty; values above DEPTH act as DEPTH, zero blocks every push.
module bounded_double_ended_queue #(
	parameter int unsigned DEPTH = ddq_pkg::DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [10:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // op[2:0], insert_value[34:3], zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata    // ok[0], front_value[32:1], rear_value[64:33],
	                                // is_empty[65], is_full[66], zero pad
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic                        mem_we;
	logic [PW-1:0]               mem_waddr;
	logic [ddq_pkg::WORD_W-1:0]  mem_wdata;
	logic                        mem_re;
	logic [PW-1:0]               mem_raddr0;
	logic [PW-1:0]               mem_raddr1;
	logic [ddq_pkg::WORD_W-1:0]  mem_rdata0;
	logic [ddq_pkg::WORD_W-1:0]  mem_rdata1;
	logic                        res_ok;
	logic [ddq_pkg::WORD_W-1:0]  res_front;
	logic [ddq_pkg::WORD_W-1:0]  res_rear;
	logic                        res_empty;
	logic                        res_full;

	ddq_ctrl #(
		.DEPTH (DEPTH),
		.PW    (PW),
		.CW    (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tdata[2:0]),
		.in_value   (s_tdata[34:3]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_ok     (res_ok),
		.out_front  (res_front),
		.out_rear   (res_rear),
		.out_empty  (res_empty),
		.out_full   (res_full),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr0 (mem_raddr0),
		.mem_raddr1 (mem_raddr1),
		.mem_rdata0 (mem_rdata0),
		.mem_rdata1 (mem_rdata1)
	);

	ddq_store #(
		.DEPTH (DEPTH),
		.PW    (PW)
	) u_store (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr0 (mem_raddr0),
		.raddr1 (mem_raddr1),
		.rdata0 (mem_rdata0),
		.rdata1 (mem_rdata1)
	);

	assign m_tdata = {5'b0, res_full, res_empty, res_rear, res_front, res_ok};

endmodule

### sv/ddq_checker.sv
// ----------------------------------------------------------------------------
// ddq_checker
// Port-level checks for the bounded double-ended queue.
// ----------------------------------------------------------------------------
module ddq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [71:0]  m_tdata
);

	// empty queue reports all-ones front and rear
	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65] |-> m_tdata[32:1] == 32'hFFFF_FFFF
			&& m_tdata[64:33] == 32'hFFFF_FFFF)
		else $error("empty result without all-ones words");

	// a failed request on a queue that is not empty must find the queue full
	a_pop_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] && !m_tdata[65] |-> m_tdata[66])
		else $error("failed request on a queue neither empty nor full");

	// one request in flight at a time
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

endmodule

bind bounded_double_ended_queue ddq_checker u_ddq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_double_ended_queue. Requests are sent in
// random bursts; a local deque model predicts each result, and the
// results are checked field by field as they leave the block. Directed
// cases cover empty and full failures, spare op codes, capacity zero, one,
// saturation above the depth and writes refused while entries remain.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned DEPTH        = ddq_pkg::DEPTH_DEFAULT;
	localparam int          RANDOM_ITEMS = 200;
	localparam int          HOLD_CYCLES  = 200;
	localparam int          CYCLE_LIMIT  = 600000;

	localparam logic [ddq_pkg::OP_W-1:0] OP_QUERY  = 3'd4;
	localparam logic [ddq_pkg::OP_W-1:0] OP_SPARE5 = 3'd5;
	localparam logic [ddq_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [ddq_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		logic                       ok;
		logic [ddq_pkg::WORD_W-1:0] front;
		logic [ddq_pkg::WORD_W-1:0] rear;
		logic                       empty;
		logic                       full;
	} deque_status_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [ddq_pkg::CAP_W-1:0]  cfg_wdata = '0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [39:0]                s_tdata   = '0;
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [71:0]                m_tdata;

	bounded_double_ended_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local deque model
	logic [ddq_pkg::WORD_W-1:0] ring_mem [DEPTH];
	int unsigned       head_idx     = 0;
	int unsigned       live_count   = 0;
	int unsigned       cap_setting  = ddq_pkg::CAP_RESET;

	deque_status_t     pending_status[$];
	int                mismatch_count = 0;
	int                cycle_count    = 0;
	int                burst_left     = 0;
	int                rx_mode        = 0;
	logic              rx_hold        = 1'b0;
	event              hold_go;

	function automatic deque_status_t deque_apply(logic [ddq_pkg::OP_W-1:0] op,
			logic [ddq_pkg::WORD_W-1:0] val);
		int unsigned   lim;
		bit            full_now;
		bit            empty_now;
		deque_status_t r;
		lim       = (cap_setting > DEPTH) ? DEPTH : cap_setting;
		full_now  = live_count >= lim;
		empty_now = live_count == 0;
		r.ok      = 1'b1;
		case (op)
			ddq_pkg::OP_PUSH_FRONT: begin
				if (full_now) begin
					r.ok = 1'b0;
				end else begin
					head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
					ring_mem[head_idx] = val;
					live_count++;
				end
			end
			ddq_pkg::OP_PUSH_BACK: begin
				if (full_now) begin
					r.ok = 1'b0;
				end else begin
					ring_mem[(head_idx + live_count) % DEPTH] = val;
					live_count++;
				end
			end
			ddq_pkg::OP_POP_FRONT: begin
				if (empty_now) begin
					r.ok = 1'b0;
				end else begin
					head_idx = (head_idx + 1) % DEPTH;
					live_count--;
				end
			end
			ddq_pkg::OP_POP_BACK: begin
				if (empty_now) r.ok = 1'b0;
				else live_count--;
			end
			default: ;
		endcase
		r.front = ddq_pkg::EMPTY_WORD;
		r.rear  = ddq_pkg::EMPTY_WORD;
		if (live_count != 0) begin
			r.front = ring_mem[head_idx];
			r.rear  = ring_mem[(head_idx + live_count - 1) % DEPTH];
		end
		r.empty = live_count == 0;
		r.full  = live_count >= lim;
		return r;
	endfunction

	function automatic logic [ddq_pkg::WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '1;
			3: return '0;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_request(input logic [ddq_pkg::OP_W-1:0] op,
			input logic [ddq_pkg::WORD_W-1:0] val);
		int            gap;
		deque_status_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, val, op};
		do @(posedge clk); while (!s_tready);
		predicted = deque_apply(op, val);
		pending_status.insert(pending_status.size(), predicted);
		burst_left--;
	endtask

	// stop offering and wait for every outstanding request to complete
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_status.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_capacity(input logic [ddq_pkg::CAP_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (live_count == 0) cap_setting = value;
	endtask

	function automatic logic [ddq_pkg::OP_W-1:0] rand_pop();
		return $urandom_range(0, 1) ? ddq_pkg::OP_POP_FRONT : ddq_pkg::OP_POP_BACK;
	endfunction

	function automatic logic [ddq_pkg::OP_W-1:0] rand_push();
		return $urandom_range(0, 1) ? ddq_pkg::OP_PUSH_FRONT : ddq_pkg::OP_PUSH_BACK;
	endfunction

	task automatic empty_queue();
		while (live_count != 0) send_request(rand_pop(), rand_word());
	endtask

	task automatic test_basic_ops();
		send_request(ddq_pkg::OP_POP_FRONT, 32'h1234_5678);
		send_request(ddq_pkg::OP_POP_BACK, 32'h0);
		send_request(OP_QUERY, 32'hffff_ffff);
		send_request(OP_SPARE5, 32'h5555_5555);
		send_request(OP_SPARE6, 32'haaaa_aaaa);
		send_request(OP_SPARE7, 32'h0);
		send_request(ddq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
		send_request(ddq_pkg::OP_PUSH_BACK, 32'h8000_0000);
		send_request(ddq_pkg::OP_PUSH_FRONT, 32'hffff_ffff);
		send_request(ddq_pkg::OP_PUSH_BACK, 32'h0);
		send_request(OP_QUERY, 32'h0);
		send_request(ddq_pkg::OP_POP_FRONT, 32'h0);
		send_request(ddq_pkg::OP_POP_BACK, 32'h0);
		send_request(ddq_pkg::OP_POP_FRONT, 32'h0);
		send_request(ddq_pkg::OP_POP_BACK, 32'h0);
		send_request(ddq_pkg::OP_POP_BACK, 32'h0);
	endtask

	task automatic test_capacity_edges();
		write_capacity(11'd1);
		send_request(ddq_pkg::OP_PUSH_BACK, 32'hdead_beef);
		send_request(ddq_pkg::OP_PUSH_FRONT, 32'h0bad_f00d);
		send_request(ddq_pkg::OP_POP_FRONT, 32'h0);
		write_capacity(11'd0);
		send_request(ddq_pkg::OP_PUSH_FRONT, 32'h1);
		send_request(ddq_pkg::OP_PUSH_BACK, 32'h2);
		send_request(OP_QUERY, 32'h0);
		write_capacity(11'd3);
		send_request(ddq_pkg::OP_PUSH_BACK, 32'h8000_0001);
		send_request(ddq_pkg::OP_PUSH_BACK, 32'h7fff_fffe);
		// refused: entries still held
		write_capacity(11'd1);
		send_request(ddq_pkg::OP_PUSH_FRONT, 32'hcafe_0001);
		send_request(ddq_pkg::OP_PUSH_BACK, 32'hcafe_0002);
		empty_queue();
		send_request(ddq_pkg::OP_POP_FRONT, 32'h0);
	endtask

	task automatic test_output_hold();
		write_capacity(11'd24);
		-> hold_go;
		repeat (50) begin
			if ($urandom_range(0, 4) != 0) send_request(rand_push(), rand_word());
			else send_request(rand_pop(), rand_word());
		end
		empty_queue();
		settle();
	endtask

	// capacity above the depth saturates at the depth
	task automatic test_full_depth();
		write_capacity(11'd2047);
		repeat (DEPTH) send_request(rand_push(), rand_word());
		send_request(ddq_pkg::OP_PUSH_FRONT, rand_word());
		send_request(ddq_pkg::OP_PUSH_BACK, rand_word());
		send_request(OP_QUERY, rand_word());
		repeat (8) send_request(rand_pop(), rand_word());
		send_request(rand_push(), rand_word());
		send_request(OP_QUERY, rand_word());
	endtask

	task automatic test_random_traffic();
		int                        done;
		int                        phase_len;
		int                        push_pct;
		int                        roll;
		logic [ddq_pkg::CAP_W-1:0] cap;
		logic [ddq_pkg::OP_W-1:0]  op;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: cap = 11'd1;
				1: cap = 11'($urandom_range(2, 4));
				2: cap = 11'($urandom_range(5, 16));
				3: cap = 11'($urandom_range(17, 64));
				4: cap = 11'($urandom_range(1, DEPTH));
				default: cap = 11'($urandom_range(0, 2047));
			endcase
			write_capacity(cap);
			phase_len = $urandom_range(40, 120);
			case ($urandom_range(0, 2))
				0: push_pct = 70;
				1: push_pct = 30;
				default: push_pct = 50;
			endcase
			repeat (phase_len) begin
				roll = $urandom_range(0, 99);
				if (roll < 6) op = 3'($urandom_range(OP_QUERY, OP_SPARE7));
				else if (roll < 6 + push_pct * 94 / 100) op = rand_push();
				else op = rand_pop();
				send_request(op, rand_word());
				done++;
			end
			if ($urandom_range(0, 4) != 0) begin
				while (live_count != 0) begin
					send_request(rand_pop(), rand_word());
					done++;
				end
			end
		end
		empty_queue();
	endtask

	task automatic check_field(input string name, input logic [ddq_pkg::WORD_W-1:0] want,
			input logic [ddq_pkg::WORD_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	// result checker and output stall pattern
	always @(posedge clk) begin
		deque_status_t want;
		if (m_tvalid && m_tready) begin
			if (pending_status.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				want = pending_status.pop_front();
				check_field("ok", want.ok, m_tdata[0]);
				check_field("front", want.front, m_tdata[32:1]);
				check_field("rear", want.rear, m_tdata[64:33]);
				check_field("empty", want.empty, m_tdata[65]);
				check_field("full", want.full, m_tdata[66]);
			end
		end
		if (cycle_count % 50 == 0) rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= !rx_hold;
			1: m_tready <= !rx_hold && $urandom_range(0, 1);
			2: m_tready <= !rx_hold && ($urandom_range(0, 3) != 0);
			default: m_tready <= !rx_hold && cycle_count[2];
		endcase
	end

	initial begin
		forever begin
			@hold_go;
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_capacity_edges();
		test_output_hold();
		test_random_traffic();
		test_full_depth();
		settle();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && pending_status.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
